/* rtl/core/contiguous_frame_allocator_core_defines.svh */
// Assertion macros for the contiguous frame allocator core.
// Used by the port checker; needs a clock and a reset signal in scope.
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CFA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/cfa_pkg.sv */
// Shared codes and control/status structs of the contiguous frame allocator.
// No dependencies.
package cfa_pkg;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_MARK    = 2'd2;

   localparam logic [1:0] FS_FREE = 2'd0;
   localparam logic [1:0] FS_USED = 2'd1;
   localparam logic [1:0] FS_HEAD = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM  = 2'd1;
   localparam logic [1:0] STATUS_NOT_HEAD = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd3;

   typedef enum logic [1:0] {
      FREE_HOLD = 2'd0,
      FREE_INC  = 2'd1,
      FREE_DEC  = 2'd2,
      FREE_SUB  = 2'd3
   } free_op_type;

   typedef struct packed {
      logic        clr_start;
      logic        clr_step;
      logic        free_init;
      logic        req_load;
      logic        scan_start;
      logic        walk_start;
      logic        rd_en;
      logic        run_upd;
      logic        fill_start;
      logic        fill_step;
      logic        wr_pend;
      logic [1:0]  wr_code;
      free_op_type free_op;
      logic        set_status;
      logic [1:0]  status_code;
      logic        set_head;
      logic        out_ld;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       clr_last;
      logic       alloc_reject;
      logic       rel_out;
      logic       mark_out;
      logic       ptr_lt_n;
      logic       pend;
      logic [1:0] p_data;
      logic       p_first;
      logic       p_last;
      logic       p_mend;
      logic       run_hit;
      logic       fill_last;
      logic       out_free;
   } sts_type;

endpackage

/* rtl/core/contiguous_frame_allocator_core.sv */
// Top level of the contiguous frame allocator: register port, sequencer and
// datapath. Depends on cfa_pkg, cfa_ctrl and cfa_datapath.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | mode, frame_number, frame_count
//   rsp     | out       | rsp_valid/rsp_stall | head_frame, status, free_count
//   csr     | in/out    | psel/penable/pready | base_frame, pool_frames
//
// One item at a time. An allocate searches the pool, reading one frame state per
// cycle, then fills the run at one frame per cycle. A release or mark walks its
// frames; the sequencer returns to idle after each result before the next accept.
// Reset and a register write while idle or clearing start a clearing pass over
// the memory; items are stalled meanwhile. A result waits in the output
// register while rsp_stall is high.
module contiguous_frame_allocator_core #(
   parameter int POOL_DEPTH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [19:0] req_frame_number,
   input  logic [13:0] req_frame_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [19:0] rsp_head_frame,
   output logic [1:0]  rsp_status,
   output logic [13:0] rsp_free_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cfa_pkg::*;

   localparam logic REG_BASE = 1'b0;

   logic [19:0] base_ff;
   logic [13:0] pool_ff;
   logic        cfg_we;
   cmd_type     cmd;
   sts_type     sts;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_BASE) ? {12'd0, base_ff} : {18'd0, pool_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 20'd0;
         pool_ff <= 14'd8192;
      end else if (cfg_we) begin
         if (csr_paddr[2] == REG_BASE) begin
            base_ff <= csr_pwdata[19:0];
         end else begin
            pool_ff <= csr_pwdata[13:0];
         end
      end
   end

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_we    (cfg_we),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfa_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .base_frame       (base_ff),
      .pool_frames      (pool_ff),
      .req_mode         (req_mode),
      .req_frame_number (req_frame_number),
      .req_frame_count  (req_frame_count),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_head_frame   (rsp_head_frame),
      .rsp_status       (rsp_status),
      .rsp_free_count   (rsp_free_count),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

/* rtl/core/cfa_ctrl.sv */
// Sequencer of the contiguous frame allocator: clear, search, fill and walk.
// Depends on cfa_pkg; drives the datapath only through cmd and sts.
module cfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_we,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfa_pkg::sts_type sts,
   output cfa_pkg::cmd_type cmd
);
   import cfa_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_FILL   = 7'b0010000,
      S_WALK   = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      hit;

   assign req_stall = (state_ff != S_IDLE);
   assign hit = sts.pend && (sts.p_data == FS_FREE) && sts.run_hit;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (cfg_we) begin
               cmd.clr_start = 1'b1;
            end else if (sts.clr_last) begin
               cmd.free_init = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cfg_we) begin
               cmd.clr_start = 1'b1;
               state_in = S_CLEAR;
            end else if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (sts.mode)
               MODE_ALLOC: begin
                  if (sts.alloc_reject) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_NO_ROOM;
                     state_in = S_FINISH;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               MODE_RELEASE: begin
                  if (sts.rel_out) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_OUTSIDE;
                     state_in = S_FINISH;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in = S_WALK;
                  end
               end
               MODE_MARK: begin
                  if (sts.mark_out) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_OUTSIDE;
                     state_in = S_FINISH;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in = S_WALK;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            cmd.rd_en   = sts.ptr_lt_n && !hit;
            cmd.run_upd = sts.pend;
            if (hit) begin
               cmd.fill_start = 1'b1;
               state_in = S_FILL;
            end else if (sts.pend && sts.p_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_NO_ROOM;
               state_in = S_FINISH;
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               cmd.free_op  = FREE_SUB;
               cmd.set_head = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_WALK: begin
            cmd.rd_en = sts.ptr_lt_n;
            if (sts.pend) begin
               if (sts.mode == MODE_MARK) begin
                  cmd.wr_pend = 1'b1;
                  cmd.wr_code = sts.p_first ? FS_HEAD : FS_USED;
                  if (sts.p_data == FS_FREE) begin
                     cmd.free_op = FREE_DEC;
                  end
                  if (sts.p_mend) begin
                     state_in = S_FINISH;
                  end
               end else if (sts.p_first && (sts.p_data != FS_HEAD)) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_NOT_HEAD;
                  state_in = S_FINISH;
               end else if (sts.p_first || (sts.p_data == FS_USED)) begin
                  // The head, and each allocated frame after it, returns to free.
                  cmd.wr_pend = 1'b1;
                  cmd.wr_code = FS_FREE;
                  cmd.free_op = FREE_INC;
                  if (sts.p_last) begin
                     state_in = S_FINISH;
                  end
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.out_ld = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/cfa_datapath.sv */
// Datapath of the contiguous frame allocator: frame state memory, pointers,
// run and free counters, request latch and result register. Uses cfa_pkg.
module cfa_datapath #(
   parameter int POOL_DEPTH = 8192
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [19:0]      base_frame,
   input  logic [13:0]      pool_frames,
   input  logic [1:0]       req_mode,
   input  logic [19:0]      req_frame_number,
   input  logic [13:0]      req_frame_count,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [19:0]      rsp_head_frame,
   output logic [1:0]       rsp_status,
   output logic [13:0]      rsp_free_count,
   input  cfa_pkg::cmd_type cmd,
   output cfa_pkg::sts_type sts
);
   import cfa_pkg::*;

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int PW = IW + 1;
   localparam int SW = (IW + 1 < 14) ? IW + 1 : 14;
   localparam logic [16:0] DEPTH17 = 17'(POOL_DEPTH);

   logic [1:0]    mem [POOL_DEPTH];

   logic [1:0]    mode_ff;
   logic [19:0]   fno_ff;
   logic [13:0]   cnt_ff;
   logic [PW-1:0] ptr_ff;
   logic          pend_ff;
   logic [IW-1:0] p_idx_ff;
   logic [1:0]    rd_data_ff;
   logic [SW-1:0] run_ff;
   logic [SW-1:0] free_ff;
   logic [IW-1:0] head_idx_ff;
   logic [IW-1:0] fill_end_ff;
   logic [1:0]    status_ff;
   logic [19:0]   head_out_ff;
   logic          rsp_valid_ff;
   logic [19:0]   rsp_head_ff;
   logic [1:0]    rsp_status_ff;
   logic [13:0]   rsp_free_ff;

   logic [16:0]   n_wide;
   logic [SW-1:0] n;
   logic [20:0]   off;
   logic          rel_out;
   logic [IW-1:0] idx;
   logic [16:0]   mend;
   logic [16:0]   head_calc;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [1:0]    wr_data;

   // Effective pool size is the register capped at the store depth.
   assign n_wide  = (17'(pool_frames) > DEPTH17) ? DEPTH17 : 17'(pool_frames);
   assign n       = n_wide[SW-1:0];
   assign off     = {1'b0, fno_ff} - {1'b0, base_frame};
   assign rel_out = off[20] || (off[19:0] >= 20'(n));
   assign idx     = off[IW-1:0];
   assign mend    = 17'(idx) + 17'(cnt_ff) - 17'd1;
   assign head_calc = 17'(p_idx_ff) + 17'd1 - 17'(cnt_ff);

   always_comb begin
      sts              = '0;
      sts.mode         = mode_ff;
      sts.clr_last     = (17'(ptr_ff[IW-1:0]) == DEPTH17 - 17'd1);
      sts.alloc_reject = (cnt_ff == 14'd0) || (cnt_ff > 14'(free_ff));
      sts.rel_out      = rel_out;
      sts.mark_out     = (cnt_ff == 14'd0) || rel_out ||
                         (21'(cnt_ff) > 21'(n) - off);
      sts.ptr_lt_n     = 17'(ptr_ff) < 17'(n);
      sts.pend         = pend_ff;
      sts.p_data       = rd_data_ff;
      sts.p_first      = (p_idx_ff == idx);
      sts.p_last       = (17'(p_idx_ff) == 17'(n) - 17'd1);
      sts.p_mend       = (17'(p_idx_ff) == mend);
      sts.run_hit      = (15'(run_ff) + 15'd1 == 15'(cnt_ff));
      sts.fill_last    = (ptr_ff[IW-1:0] == fill_end_ff);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[IW-1:0];
      wr_data = FS_FREE;
      if (cmd.clr_step) begin
         wr_en = 1'b1;
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_data = (ptr_ff[IW-1:0] == head_idx_ff) ? FS_HEAD : FS_USED;
      end else if (cmd.wr_pend) begin
         wr_en   = 1'b1;
         wr_addr = p_idx_ff;
         wr_data = cmd.wr_code;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[ptr_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff <= ptr_ff[IW-1:0];
      // The clearing pass after reset starts at entry zero.
      if (reset || cmd.clr_start || cmd.scan_start) begin
         ptr_ff <= '0;
      end else if (cmd.walk_start) begin
         ptr_ff <= PW'(idx);
      end else if (cmd.fill_start) begin
         ptr_ff <= PW'(head_calc[IW-1:0]);
      end else if (cmd.clr_step || cmd.fill_step || cmd.rd_en) begin
         ptr_ff <= ptr_ff + PW'(1);
      end
      if (cmd.scan_start) begin
         run_ff <= '0;
      end else if (cmd.run_upd) begin
         run_ff <= (rd_data_ff == FS_FREE) ? run_ff + SW'(1) : '0;
      end
      if (cmd.fill_start) begin
         head_idx_ff <= head_calc[IW-1:0];
         fill_end_ff <= p_idx_ff;
      end
      if (cmd.req_load) begin
         mode_ff     <= req_mode;
         fno_ff      <= req_frame_number;
         cnt_ff      <= req_frame_count;
         status_ff   <= STATUS_OK;
         head_out_ff <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.set_head) begin
            head_out_ff <= base_frame + 20'(head_idx_ff);
         end
      end
      if (cmd.out_ld) begin
         rsp_head_ff   <= head_out_ff;
         rsp_status_ff <= status_ff;
         rsp_free_ff   <= 14'(free_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '0;
      end else begin
         pend_ff <= cmd.rd_en;
         if (cmd.out_ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.free_init) begin
            free_ff <= n;
         end else begin
            unique case (cmd.free_op)
               FREE_HOLD: free_ff <= free_ff;
               FREE_INC:  free_ff <= free_ff + SW'(1);
               FREE_DEC:  free_ff <= free_ff - SW'(1);
               FREE_SUB:  free_ff <= free_ff - cnt_ff[SW-1:0];
               default:   free_ff <= free_ff;
            endcase
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_frame = rsp_head_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

/* rtl/core/cfa_checker.sv */
// Port checker for the contiguous frame allocator, bound to the top level.
// Depends on cfa_pkg and the assertion macro header.
`include "contiguous_frame_allocator_core_defines.svh"

module cfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [19:0] rsp_head_frame,
   input logic [1:0]  rsp_status
);
   import cfa_pkg::*;

   // The block works on one item at a time, so it is busy after an accept.
   `CFA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted while busy")

   // Only a successful allocate carries a head frame.
   `CFA_ASSERT_NOW(a_head_zero_on_fail, rsp_valid && (rsp_status != STATUS_OK), rsp_head_frame == 20'd0, "head on failed request")

   `CFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   `CFA_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_head_frame) && $stable(rsp_status), "stalled result changed")

endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_head_frame (rsp_head_frame),
   .rsp_status     (rsp_status)
);
